[hw/rtl/pcae_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pcae_pkg;

  // defaults of the top level parameters
  localparam int MAX_SAMPLES_DEF      = 1024;
  localparam int BASELINE_SAMPLES_DEF = 5;

  // fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int CH_W      = 6;
  localparam int TS_W      = 64;
  localparam int WIN_W     = 10;
  localparam int AMP_W     = 16;
  localparam int CHARGE_W  = 30;

  // job record widths, sized for the largest parameter values
  localparam int CNT_MAX_W  = 17;
  localparam int BSUM_MAX_W = 20;
  localparam int WSUM_MAX_W = 32;

  localparam int QUEUE_DEPTH = 2;

  // apb register map, 64-bit data at byte address 8*i
  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_FIRST  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LAST   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SLICE_LENGTH  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SMALL_LIMIT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SMALL_CHANNEL = 3'd4;

  localparam logic [WIN_W-1:0]    WINDOW_FIRST_RST  = 10'd8;
  localparam logic [WIN_W-1:0]    WINDOW_LAST_RST   = 10'd37;
  localparam logic [TS_W-1:0]     SLICE_LENGTH_RST  = 64'd1000000000;
  localparam logic [AMP_W-1:0]    SMALL_LIMIT_RST   = 16'd17;
  localparam logic [CH_W-1:0]     SMALL_CHANNEL_RST = 6'd55;

  typedef struct packed {
    logic [WIN_W-1:0] window_first;
    logic [WIN_W-1:0] window_last;
    logic [TS_W-1:0]  slice_length;
    logic [AMP_W-1:0] small_limit;
    logic [CH_W-1:0]  small_channel;
  } cfg_t;

  // one finished waveform, handed from front to back
  typedef struct packed {
    logic [CH_W-1:0]            channel;
    logic [TS_W-1:0]            timestamp;
    logic [CNT_MAX_W-1:0]       count;
    logic signed [BSUM_MAX_W-1:0] bsum;
    logic signed [WSUM_MAX_W-1:0] wsum;
    logic signed [SAMPLE_W-1:0] wmax;
    logic signed [SAMPLE_W-1:0] wmin;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

[hw/rtl/pcae_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none

interface pcae_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcae_pkg::SAMPLE_W-1:0] sample;
  logic [pcae_pkg::CH_W-1:0]           channel;
  logic [pcae_pkg::TS_W-1:0]           timestamp;
  logic                                first;
  logic                                last;

  modport source(output valid, sample, channel, timestamp, first, last, input ready);
  modport sink(input valid, sample, channel, timestamp, first, last, output ready);
endinterface

interface pcae_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [pcae_pkg::CH_W-1:0]             pulse_channel;
  logic [pcae_pkg::AMP_W-1:0]            amplitude_counts;
  logic signed [pcae_pkg::CHARGE_W-1:0]  charge_scaled;
  logic [pcae_pkg::TS_W-1:0]             slice_index;
  logic [pcae_pkg::TS_W-1:0]             slice_offset;
  logic                                  small_pulse;
  logic                                  window_empty;

  modport source(output valid, pulse_channel, amplitude_counts, charge_scaled, slice_index,
                 slice_offset, small_pulse, window_empty, input ready);
  modport sink(input valid, pulse_channel, amplitude_counts, charge_scaled, slice_index,
               slice_offset, small_pulse, window_empty, output ready);
endinterface

`default_nettype wire

[hw/rtl/pcae_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module pcae_front #(
  parameter int MAX_SAMPLES      = pcae_pkg::MAX_SAMPLES_DEF,
  parameter int BASELINE_SAMPLES = pcae_pkg::BASELINE_SAMPLES_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  pcae_in_if.sink                in_ch,
  input  pcae_pkg::cfg_t         cfg,
  input  pcae_pkg::queue_stat_t  q_stat,
  output logic                   push,
  output pcae_pkg::job_t         job
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int BSUM_W = pcae_pkg::SAMPLE_W + $clog2(BASELINE_SAMPLES);
  localparam int WSUM_W = pcae_pkg::SAMPLE_W + $clog2(MAX_SAMPLES);
  localparam int CMP_W  = (CNT_W > pcae_pkg::WIN_W) ? CNT_W : pcae_pkg::WIN_W;

  localparam logic signed [pcae_pkg::SAMPLE_W-1:0] S_MOST_NEG = {1'b1, {(pcae_pkg::SAMPLE_W-1){1'b0}}};
  localparam logic signed [pcae_pkg::SAMPLE_W-1:0] S_MOST_POS = {1'b0, {(pcae_pkg::SAMPLE_W-1){1'b1}}};

  logic [CNT_W-1:0]                   sample_index;
  logic signed [BSUM_W-1:0]           baseline_sum;
  logic signed [WSUM_W-1:0]           window_sum;
  logic [CNT_W-1:0]                   window_count;
  logic signed [pcae_pkg::SAMPLE_W-1:0] window_max;
  logic signed [pcae_pkg::SAMPLE_W-1:0] window_min;
  logic [pcae_pkg::CH_W-1:0]          held_channel;
  logic [pcae_pkg::TS_W-1:0]          held_timestamp;

  logic [CNT_W-1:0]                   sample_index_next;
  logic signed [BSUM_W-1:0]           baseline_sum_next;
  logic signed [WSUM_W-1:0]           window_sum_next;
  logic [CNT_W-1:0]                   window_count_next;
  logic signed [pcae_pkg::SAMPLE_W-1:0] window_max_next;
  logic signed [pcae_pkg::SAMPLE_W-1:0] window_min_next;
  logic [pcae_pkg::CH_W-1:0]          held_channel_next;
  logic [pcae_pkg::TS_W-1:0]          held_timestamp_next;

  // accumulator values as seen by this sample (cleared on first)
  logic [CNT_W-1:0]                   idx_cur;
  logic signed [BSUM_W-1:0]           bsum_cur;
  logic signed [WSUM_W-1:0]           wsum_cur;
  logic [CNT_W-1:0]                   cnt_cur;
  logic signed [pcae_pkg::SAMPLE_W-1:0] max_cur;
  logic signed [pcae_pkg::SAMPLE_W-1:0] min_cur;
  logic [CMP_W-1:0]                   idx_ext;
  logic                               active;
  logic                               in_base;
  logic                               in_win;
  logic                               take;

  assign in_ch.ready = !q_stat.full;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    idx_cur  = in_ch.first ? '0 : sample_index;
    bsum_cur = in_ch.first ? '0 : baseline_sum;
    wsum_cur = in_ch.first ? '0 : window_sum;
    cnt_cur  = in_ch.first ? '0 : window_count;
    max_cur  = in_ch.first ? S_MOST_NEG : window_max;
    min_cur  = in_ch.first ? S_MOST_POS : window_min;

    idx_ext = CMP_W'(idx_cur);
    active  = idx_cur < CNT_W'(MAX_SAMPLES);
    in_base = active && (idx_ext < CMP_W'(BASELINE_SAMPLES));
    in_win  = active && (idx_ext >= CMP_W'(cfg.window_first))
                     && (idx_ext <= CMP_W'(cfg.window_last));

    sample_index_next = active ? idx_cur + CNT_W'(1) : idx_cur;
    baseline_sum_next = in_base ? bsum_cur + BSUM_W'(in_ch.sample) : bsum_cur;
    window_sum_next   = in_win ? wsum_cur + WSUM_W'(in_ch.sample) : wsum_cur;
    window_count_next = in_win ? cnt_cur + CNT_W'(1) : cnt_cur;
    window_max_next   = (in_win && (in_ch.sample > max_cur)) ? in_ch.sample : max_cur;
    window_min_next   = (in_win && (in_ch.sample < min_cur)) ? in_ch.sample : min_cur;

    held_channel_next   = in_ch.first ? in_ch.channel : held_channel;
    held_timestamp_next = in_ch.first ? in_ch.timestamp : held_timestamp;
  end

  // channel zero closes its waveform without a job
  assign push = take && in_ch.last && (held_channel_next != '0);

  always_comb begin
    job.channel   = held_channel_next;
    job.timestamp = held_timestamp_next;
    job.count     = pcae_pkg::CNT_MAX_W'(window_count_next);
    job.bsum      = pcae_pkg::BSUM_MAX_W'(baseline_sum_next);
    job.wsum      = pcae_pkg::WSUM_MAX_W'(window_sum_next);
    job.wmax      = window_max_next;
    job.wmin      = window_min_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index   <= '0;
      baseline_sum   <= '0;
      window_sum     <= '0;
      window_count   <= '0;
      window_max     <= S_MOST_NEG;
      window_min     <= S_MOST_POS;
      held_channel   <= '0;
      held_timestamp <= '0;
    end else if (take) begin
      held_channel   <= held_channel_next;
      held_timestamp <= held_timestamp_next;
      if (in_ch.last) begin
        sample_index <= '0;
        baseline_sum <= '0;
        window_sum   <= '0;
        window_count <= '0;
        window_max   <= S_MOST_NEG;
        window_min   <= S_MOST_POS;
      end else begin
        sample_index <= sample_index_next;
        baseline_sum <= baseline_sum_next;
        window_sum   <= window_sum_next;
        window_count <= window_count_next;
        window_max   <= window_max_next;
        window_min   <= window_min_next;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pcae_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module pcae_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  pcae_pkg::job_t         push_job,
  input  wire                    pop,
  output pcae_pkg::job_t         head,
  output pcae_pkg::queue_stat_t  q_stat
);

  localparam int PTR_W = (pcae_pkg::QUEUE_DEPTH > 1) ? $clog2(pcae_pkg::QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(pcae_pkg::QUEUE_DEPTH - 1);

  pcae_pkg::job_t   entries [pcae_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign head         = entries[rd_ptr];
  assign q_stat.full  = fill == (PTR_W+1)'(pcae_pkg::QUEUE_DEPTH);
  assign q_stat.empty = fill == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + (PTR_W+1)'(1);
        2'b01:   fill <= fill - (PTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pcae_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module pcae_back #(
  parameter int BASELINE_SAMPLES = pcae_pkg::BASELINE_SAMPLES_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  pcae_pkg::cfg_t         cfg,
  input  pcae_pkg::job_t         head,
  input  pcae_pkg::queue_stat_t  q_stat,
  output logic                   pop,
  pcae_out_if.source             out_ch
);

  localparam int PROD_W = pcae_pkg::CNT_MAX_W + 1 + pcae_pkg::BSUM_MAX_W;
  localparam int Q_W    = PROD_W + 1;
  localparam int STEP_W = $clog2(pcae_pkg::TS_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(pcae_pkg::TS_W - 1);

  localparam logic signed [Q_W-1:0] CHG_HI = Q_W'(2 ** (pcae_pkg::CHARGE_W - 1) - 1);
  localparam logic signed [Q_W-1:0] CHG_LO = -CHG_HI - Q_W'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                 state;
  pcae_pkg::job_t             job_r;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   wterm;
  logic [pcae_pkg::TS_W-1:0]  rem;
  logic [pcae_pkg::TS_W-1:0]  quo;
  logic [STEP_W-1:0]          step;

  logic [pcae_pkg::TS_W+1:0]  trial;
  logic [pcae_pkg::TS_W-1:0]  rem_next;
  logic [pcae_pkg::TS_W-1:0]  quo_next;
  logic signed [Q_W-1:0]      q_raw;
  logic signed [pcae_pkg::CHARGE_W-1:0] q_sat;
  logic signed [pcae_pkg::SAMPLE_W:0]   amp_wide;
  logic [pcae_pkg::AMP_W-1:0] amp;
  logic                       empty;
  logic                       out_free;

  assign pop      = (state == S_IDLE) && !q_stat.empty;
  assign out_free = !out_ch.valid || out_ch.ready;

  // one restoring division step
  always_comb begin
    trial = {1'b0, rem, quo[pcae_pkg::TS_W-1]} - {2'b00, cfg.slice_length};
    if (trial[pcae_pkg::TS_W+1]) begin
      rem_next = {rem[pcae_pkg::TS_W-2:0], quo[pcae_pkg::TS_W-1]};
      quo_next = {quo[pcae_pkg::TS_W-2:0], 1'b0};
    end else begin
      rem_next = trial[pcae_pkg::TS_W-1:0];
      quo_next = {quo[pcae_pkg::TS_W-2:0], 1'b1};
    end
  end

  always_comb begin
    empty    = job_r.count == '0;
    q_raw    = Q_W'(prod) - Q_W'(wterm);
    if (q_raw > CHG_HI) begin
      q_sat = pcae_pkg::CHARGE_W'(CHG_HI);
    end else if (q_raw < CHG_LO) begin
      q_sat = pcae_pkg::CHARGE_W'(CHG_LO);
    end else begin
      q_sat = pcae_pkg::CHARGE_W'(q_raw);
    end
    amp_wide = (pcae_pkg::SAMPLE_W+1)'(job_r.wmax) - (pcae_pkg::SAMPLE_W+1)'(job_r.wmin);
    amp      = empty ? '0 : pcae_pkg::AMP_W'(amp_wide);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      // the result load below handles valid itself
      if (out_ch.valid && out_ch.ready && (state != S_FIN)) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            job_r <= head;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= $signed({1'b0, job_r.count}) * job_r.bsum;
          wterm <= job_r.wsum * $signed(PROD_W'(BASELINE_SAMPLES));
          rem   <= '0;
          quo   <= job_r.timestamp;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= rem_next;
          quo  <= quo_next;
          step <= step + STEP_W'(1);
          if (step == STEP_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_ch.valid            <= 1'b1;
            out_ch.pulse_channel    <= job_r.channel;
            out_ch.amplitude_counts <= amp;
            out_ch.charge_scaled    <= empty ? '0 : q_sat;
            out_ch.slice_index      <= quo;
            out_ch.slice_offset     <= rem;
            out_ch.small_pulse      <= (job_r.channel > cfg.small_channel)
                                       && (amp < cfg.small_limit);
            out_ch.window_empty     <= empty;
            state                   <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pulse_charge_amplitude_extract.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake       payload
// in_ch     in         valid/ready     sample, channel, timestamp, first, last
// out_ch    out        valid/ready     pulse_channel, amplitude_counts, charge_scaled,
//                                      slice_index, slice_offset, small_pulse, window_empty
// apb       in         psel/penable    paddr, pwdata, prdata (pready tied high)
//
// samples: one transfer per clock while the job queue has room
// per waveform: the back end steps through pop, multiply, 64-step restoring
//   divide of timestamp by slice_length and result load, one waveform at a time
// quickly closing waveforms fill the two-entry queue and stall in_ch
// rst is synchronous, active high; clears accumulators, queue and registers
// a result waiting on out_ch holds only the last back end cycle

module pulse_charge_amplitude_extract #(
  parameter int MAX_SAMPLES      = pcae_pkg::MAX_SAMPLES_DEF,
  parameter int BASELINE_SAMPLES = pcae_pkg::BASELINE_SAMPLES_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  pcae_in_if.sink                          in_ch,
  pcae_out_if.source                       out_ch,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [pcae_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire [pcae_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pcae_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  pcae_pkg::cfg_t              cfg;
  pcae_pkg::job_t              push_job;
  pcae_pkg::job_t              head;
  pcae_pkg::queue_stat_t       q_stat;
  logic                        push;
  logic                        pop;
  logic                        cfg_wr;
  logic [pcae_pkg::REG_IDX_W-1:0] reg_idx;

  // ---------------------------------------------------------------------------
  // configuration registers, one per 8-byte slot
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[pcae_pkg::APB_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_first  <= pcae_pkg::WINDOW_FIRST_RST;
      cfg.window_last   <= pcae_pkg::WINDOW_LAST_RST;
      cfg.slice_length  <= pcae_pkg::SLICE_LENGTH_RST;
      cfg.small_limit   <= pcae_pkg::SMALL_LIMIT_RST;
      cfg.small_channel <= pcae_pkg::SMALL_CHANNEL_RST;
    end else if (cfg_wr) begin
      // writes to unused slots are dropped
      unique case (reg_idx)
        pcae_pkg::REG_WINDOW_FIRST:  cfg.window_first  <= pwdata[pcae_pkg::WIN_W-1:0];
        pcae_pkg::REG_WINDOW_LAST:   cfg.window_last   <= pwdata[pcae_pkg::WIN_W-1:0];
        pcae_pkg::REG_SLICE_LENGTH:  cfg.slice_length  <= pwdata[pcae_pkg::TS_W-1:0];
        pcae_pkg::REG_SMALL_LIMIT:   cfg.small_limit   <= pwdata[pcae_pkg::AMP_W-1:0];
        pcae_pkg::REG_SMALL_CHANNEL: cfg.small_channel <= pwdata[pcae_pkg::CH_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (reg_idx)
      pcae_pkg::REG_WINDOW_FIRST:  prdata = pcae_pkg::APB_DATA_W'(cfg.window_first);
      pcae_pkg::REG_WINDOW_LAST:   prdata = pcae_pkg::APB_DATA_W'(cfg.window_last);
      pcae_pkg::REG_SLICE_LENGTH:  prdata = pcae_pkg::APB_DATA_W'(cfg.slice_length);
      pcae_pkg::REG_SMALL_LIMIT:   prdata = pcae_pkg::APB_DATA_W'(cfg.small_limit);
      pcae_pkg::REG_SMALL_CHANNEL: prdata = pcae_pkg::APB_DATA_W'(cfg.small_channel);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // front end: per-sample baseline and window accumulation, one job per
  // closed waveform on a nonzero channel
  // ---------------------------------------------------------------------------
  pcae_front #(
    .MAX_SAMPLES      (MAX_SAMPLES),
    .BASELINE_SAMPLES (BASELINE_SAMPLES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_stat (q_stat),
    .push   (push),
    .job    (push_job)
  );

  // short job queue so the sample side keeps going while the back end divides
  pcae_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // ---------------------------------------------------------------------------
  // back end: charge multiply, timestamp slicing, output register
  // ---------------------------------------------------------------------------
  pcae_back #(
    .BASELINE_SAMPLES (BASELINE_SAMPLES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("job popped from an empty queue");

  a_no_channel_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.pulse_channel != '0))
    else $error("result issued for channel zero");

  a_empty_zeroes: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.window_empty) |->
      (out_ch.amplitude_counts == '0) && (out_ch.charge_scaled == '0))
    else $error("empty window with nonzero amplitude or charge");

endmodule

`default_nettype wire

[tb/tb_pulse_charge_amplitude_extract.sv]
`timescale 1ns / 1ps

module tb_pulse_charge_amplitude_extract;
  import pcae_pkg::*;

  localparam int BASE_N       = BASELINE_SAMPLES_DEF;
  localparam int MAX_N        = MAX_SAMPLES_DEF;
  // slack for the back end to finish its current waveform
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;

  localparam longint CHARGE_TOP    = (longint'(1) <<< (CHARGE_W - 1)) - 1;
  localparam longint CHARGE_BOTTOM = -(longint'(1) <<< (CHARGE_W - 1));

  // one finished pulse as it leaves the block
  typedef struct packed {
    logic [CH_W-1:0]            channel;
    logic [AMP_W-1:0]           amplitude;
    logic signed [CHARGE_W-1:0] charge;
    logic [TS_W-1:0]            slice_index;
    logic [TS_W-1:0]            slice_offset;
    logic                       small_flag;
    logic                       empty_flag;
  } pulse_t;

  // tracks the waveform being summed and holds the pulses still to come out
  class pulse_scoreboard;
    logic [WIN_W-1:0]           win_first, win_last;
    logic [TS_W-1:0]            slice_len;
    logic [AMP_W-1:0]           small_limit;
    logic [CH_W-1:0]            small_chan;
    logic [10:0]                sample_idx, win_count;
    logic signed [19:0]         base_sum;
    logic signed [26:0]         win_sum;
    logic signed [SAMPLE_W-1:0] win_max, win_min;
    logic [CH_W-1:0]            held_ch;
    logic [TS_W-1:0]            held_ts;
    pulse_t                     pending_pulses[$];
    int                         pulses_expected;
    int                         errors;

    function new();
      win_first       = WINDOW_FIRST_RST;
      win_last        = WINDOW_LAST_RST;
      slice_len       = SLICE_LENGTH_RST;
      small_limit     = SMALL_LIMIT_RST;
      small_chan      = SMALL_CHANNEL_RST;
      held_ch         = '0;
      held_ts         = '0;
      pulses_expected = 0;
      errors          = 0;
      clear_sums();
    endfunction

    function void clear_sums();
      sample_idx = '0;
      base_sum   = '0;
      win_sum    = '0;
      win_count  = '0;
      win_max    = 16'sh8000;
      win_min    = 16'sh7fff;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
      case (idx)
        REG_WINDOW_FIRST:  win_first   = val[WIN_W-1:0];
        REG_WINDOW_LAST:   win_last    = val[WIN_W-1:0];
        REG_SLICE_LENGTH:  slice_len   = val[TS_W-1:0];
        REG_SMALL_LIMIT:   small_limit = val[AMP_W-1:0];
        REG_SMALL_CHANNEL: small_chan  = val[CH_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] smp, logic [CH_W-1:0] ch,
                              logic [TS_W-1:0] ts, logic is_first, logic is_last);
      pulse_t           p;
      longint           q;
      logic [AMP_W-1:0] amp;
      logic             no_window;
      if (is_first) begin
        clear_sums();
        held_ch = ch;
        held_ts = ts;
      end
      if (sample_idx < MAX_N) begin
        if (sample_idx < BASE_N) base_sum += smp;
        if (sample_idx >= win_first && sample_idx <= win_last) begin
          win_sum += smp;
          win_count++;
          if (smp > win_max) win_max = smp;
          if (smp < win_min) win_min = smp;
        end
        sample_idx++;
      end
      if (!is_last) return;

      no_window = (win_count == 0);
      amp = '0;
      q = 0;
      if (!no_window) begin
        amp = win_max - win_min;
        q = longint'(win_count) * longint'(base_sum) - longint'(BASE_N) * longint'(win_sum);
        if (q > CHARGE_TOP) q = CHARGE_TOP;
        if (q < CHARGE_BOTTOM) q = CHARGE_BOTTOM;
      end
      if (slice_len == 0) begin
        p.slice_index  = '1;
        p.slice_offset = held_ts;
      end else begin
        p.slice_index  = held_ts / slice_len;
        p.slice_offset = held_ts % slice_len;
      end
      clear_sums();
      if (held_ch == 0) return;

      p.channel    = held_ch;
      p.amplitude  = amp;
      p.charge     = q[CHARGE_W-1:0];
      p.small_flag = (held_ch > small_chan) && (amp < small_limit);
      p.empty_flag = no_window;
      pending_pulses.push_back(p);
      pulses_expected++;
    endfunction

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    task compare_field(string name, logic [63:0] got_val, logic [63:0] want_val);
      if (got_val !== want_val)
        report($sformatf("%s got %0h expected %0h", name, got_val, want_val));
    endtask

    task check_pulse(pulse_t got);
      pulse_t want;
      if (pending_pulses.size() == 0) begin
        report($sformatf("pulse on channel %0d with none pending", got.channel));
        return;
      end
      want = pending_pulses.pop_front();
      compare_field("pulse_channel", got.channel, want.channel);
      compare_field("amplitude_counts", got.amplitude, want.amplitude);
      compare_field("charge_scaled", got.charge, want.charge);
      compare_field("slice_index", got.slice_index, want.slice_index);
      compare_field("slice_offset", got.slice_offset, want.slice_offset);
      compare_field("small_pulse", got.small_flag, want.small_flag);
      compare_field("window_empty", got.empty_flag, want.empty_flag);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  pcae_in_if  in_ch();
  pcae_out_if out_ch();

  logic                  psel, penable, pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  pulse_scoreboard sb = new();

  // idling knobs: sender gap chance and receiver stall chance, percent per cycle
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic out_hold;
  int   sent_items = 0;
  int   cycle_count = 0;

  pulse_charge_amplitude_extract #(
    .MAX_SAMPLES(MAX_N),
    .BASELINE_SAMPLES(BASE_N)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off while out_hold is set
  always @(posedge clk) begin
    out_ch.ready <= !out_hold && ($urandom_range(99) >= stall_pct);
  end

  // monitors both channels; values seen here are the ones from before the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_sample(in_ch.sample, in_ch.channel, in_ch.timestamp, in_ch.first, in_ch.last);
      if (out_ch.valid && out_ch.ready)
        sb.check_pulse(pulse_t'{out_ch.pulse_channel, out_ch.amplitude_counts,
                                out_ch.charge_scaled, out_ch.slice_index, out_ch.slice_offset,
                                out_ch.small_pulse, out_ch.window_empty});
    end
  end

  // watchdog on the whole run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pulse_charge_amplitude_extract test failed");
    $finish;
  end

  // register write: setup cycle, then access cycle until pready
  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // bus idle before returning so the next setup never overlaps this release
    @(posedge clk);
  endtask

  task automatic set_config(logic [WIN_W-1:0] wf, logic [WIN_W-1:0] wl, logic [TS_W-1:0] sl,
                            logic [AMP_W-1:0] lim, logic [CH_W-1:0] chan);
    apb_write(REG_WINDOW_FIRST, APB_DATA_W'(wf));
    apb_write(REG_WINDOW_LAST, APB_DATA_W'(wl));
    apb_write(REG_SLICE_LENGTH, APB_DATA_W'(sl));
    apb_write(REG_SMALL_LIMIT, APB_DATA_W'(lim));
    apb_write(REG_SMALL_CHANNEL, APB_DATA_W'(chan));
  endtask

  task automatic set_idling(int idle, int stall);
    idle_pct = idle;
    stall_pct <= stall;
  endtask

  // offer one sample and wait for its transfer; may idle first
  task automatic send_sample(logic signed [SAMPLE_W-1:0] smp, logic [CH_W-1:0] ch,
                             logic [TS_W-1:0] ts, logic is_first, logic is_last);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample    <= smp;
    in_ch.channel   <= ch;
    in_ch.timestamp <= ts;
    in_ch.first     <= is_first;
    in_ch.last      <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  // mostly nonzero channels, often above the small-pulse check channel
  function automatic logic [CH_W-1:0] pick_channel();
    int r;
    r = $urandom_range(15);
    if (r == 0) return '0;
    if (r < 6) return CH_W'($urandom_range(56, 63));
    return CH_W'($urandom_range(1, 63));
  endfunction

  function automatic logic [TS_W-1:0] pick_stamp();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return TS_W'($urandom);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mode 0 spreads over the full range, 1 stays near a base (small pulses),
  // 2 picks the extremes and the values around zero
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int mode, int base);
    case (mode)
      0: return SAMPLE_W'($urandom);
      1: return SAMPLE_W'(base + int'($urandom_range(20)) - 10);
      default: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
    endcase
  endfunction

  // one waveform; without the first flag it reuses the held channel and timestamp
  task automatic random_waveform(bit with_first);
    int               len, mode, base, r;
    logic [CH_W-1:0]  ch;
    logic [TS_W-1:0]  ts;
    r = $urandom_range(99);
    if (r < 75) len = $urandom_range(1, 16);
    else if (r < 95) len = $urandom_range(17, 48);
    else len = $urandom_range(49, 120);
    mode = $urandom_range(2);
    base = int'($urandom_range(64000)) - 32000;
    ch = pick_channel();
    ts = pick_stamp();
    // channel and timestamp after the opening sample must be ignored
    for (int i = 0; i < len; i++)
      send_sample(pick_sample(mode, base), (i == 0) ? ch : CH_W'($urandom),
                  (i == 0) ? ts : {$urandom, $urandom}, with_first && (i == 0), i == len - 1);
  endtask

  task automatic noise_item();
    send_sample(SAMPLE_W'($urandom), CH_W'($urandom), {$urandom, $urandom},
                $urandom_range(7) == 0, $urandom_range(7) == 0);
  endtask

  // mostly well-formed waveforms, some missing the first flag, some noise
  task automatic random_traffic(int n_items, int n_pulses);
    int start_items, start_pulses, pick;
    start_items  = sent_items;
    start_pulses = sb.pulses_expected;
    while (sent_items - start_items < n_items || sb.pulses_expected - start_pulses < n_pulses) begin
      pick = $urandom_range(99);
      if (pick < 80) random_waveform(1'b1);
      else if (pick < 90) random_waveform(1'b0);
      else noise_item();
    end
  endtask

  // close any open waveform, then let the back end go idle before the next registers
  task automatic finish_phase();
    send_sample(SAMPLE_W'($urandom), pick_channel(), pick_stamp(), 1'b0, 1'b1);
    in_ch.valid <= 1'b0;
    while (sb.pending_pulses.size() != 0) @(posedge clk);
    // extra quiet time before the bus is used again
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.sample    = '0;
    in_ch.channel   = '0;
    in_ch.timestamp = '0;
    in_ch.first     = 1'b0;
    in_ch.last      = 1'b0;
    out_ch.ready    = 1'b0;
    out_hold        = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values written back, no idling, directed cases first
    set_config(WINDOW_FIRST_RST, WINDOW_LAST_RST, SLICE_LENGTH_RST, SMALL_LIMIT_RST,
               SMALL_CHANNEL_RST);
    set_idling(0, 0);
    // one-sample waveform: window never reached, flagged small on a high channel
    send_sample(16'sh7fff, 6'd63, '1, 1'b1, 1'b1);
    // channel zero closes without a pulse
    send_sample(16'sh1234, 6'd0, 64'd5, 1'b1, 1'b0);
    send_sample(16'shffff, 6'd9, 64'd6, 1'b0, 1'b1);
    // full-scale swing across the window start: amplitude 65535
    for (int i = 0; i < 12; i++)
      send_sample((i % 2) ? 16'sh7fff : 16'sh8000, (i == 0) ? 6'd1 : 6'd0,
                  (i == 0) ? 64'd2999999999 : 64'd0, i == 0, i == 11);
    // no first flag: a new waveform on the held channel and timestamp
    for (int i = 0; i < 3; i++)
      send_sample(16'sh0040, 6'd42, 64'd7, 1'b0, i == 2);
    random_traffic(60, 3);
    finish_phase();

    // whole record in the window, unit slices, every high channel checked
    set_config(10'd0, 10'd1023, 64'd1, 16'hffff, 6'd0);
    set_idling(63, 0);
    random_traffic(60, 3);
    finish_phase();

    // inverted window is always empty; zero slice length
    set_config(10'd1023, 10'd0, 64'd0, 16'd0, 6'd63);
    set_idling(0, 63);
    random_traffic(60, 3);
    finish_phase();

    // short window, huge slices; receiver holds off so the job queue fills
    set_config(10'd3, 10'd6, '1, 16'd300, 6'd40);
    set_idling(27, 27);
    fork
      begin
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold <= 1'b0;
      end
      begin
        // short waveforms on live channels, more than the back end can hold
        for (int w = 0; w < 8; w++)
          for (int i = 0; i < 2; i++)
            send_sample(pick_sample(1, 0), CH_W'($urandom_range(1, 63)), pick_stamp(),
                        i == 0, i == 1);
        random_traffic(50, 2);
      end
    join
    finish_phase();

    // random setting to close
    set_config(WIN_W'($urandom_range(0, 20)), WIN_W'($urandom_range(0, 50)),
               {$urandom, $urandom}, AMP_W'($urandom), CH_W'($urandom));
    set_idling(27, 27);
    random_traffic(60, 3);
    finish_phase();

    if (sb.errors == 0) begin
      $display("pulse_charge_amplitude_extract test passed");
    end else begin
      $display("pulse_charge_amplitude_extract test failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/pcae_pkg.sv
hw/rtl/pcae_ifs.sv
hw/rtl/pcae_front.sv
hw/rtl/pcae_queue.sv
hw/rtl/pcae_back.sv
hw/rtl/pulse_charge_amplitude_extract.sv
tb/tb_pulse_charge_amplitude_extract.sv
